// ===== hdl/mse_pkg.sv =====
// shared constants, opcode codes and types for the mips subset execute block
package mse_pkg;

	// data memory geometry, byte addressed, split into four byte lanes
	localparam int DMEM_ADDR_W = 16;
	localparam int DMEM_BYTES  = 1 << DMEM_ADDR_W;
	localparam int DMEM_ROW_W  = DMEM_ADDR_W - 2;
	localparam int DMEM_ROWS   = DMEM_BYTES / 4;

	localparam logic [31:0] START_PC_RESET = 32'h0000_1000;
	localparam logic [31:0] JUMP_REGION    = 32'hf000_0000;

	localparam logic CMD_EXEC    = 1'b0;
	localparam logic CMD_PRELOAD = 1'b1;

	// primary opcodes
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0a;
	localparam logic [5:0] OP_SLTIU   = 6'h0b;
	localparam logic [5:0] OP_ANDI    = 6'h0c;
	localparam logic [5:0] OP_ORI     = 6'h0d;
	localparam logic [5:0] OP_XORI    = 6'h0e;
	localparam logic [5:0] OP_LUI     = 6'h0f;
	localparam logic [5:0] OP_LB      = 6'h20;
	localparam logic [5:0] OP_LH      = 6'h21;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_LBU     = 6'h24;
	localparam logic [5:0] OP_LHU     = 6'h25;
	localparam logic [5:0] OP_SB      = 6'h28;
	localparam logic [5:0] OP_SH      = 6'h29;
	localparam logic [5:0] OP_SW      = 6'h2b;

	// special function codes
	localparam logic [5:0] FN_SLL     = 6'h00;
	localparam logic [5:0] FN_SRL     = 6'h02;
	localparam logic [5:0] FN_SRA     = 6'h03;
	localparam logic [5:0] FN_JR      = 6'h08;
	localparam logic [5:0] FN_JALR    = 6'h09;
	localparam logic [5:0] FN_SYSCALL = 6'h0c;
	localparam logic [5:0] FN_ADDU    = 6'h21;
	localparam logic [5:0] FN_SUBU    = 6'h23;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_XOR     = 6'h26;
	localparam logic [5:0] FN_NOR     = 6'h27;
	localparam logic [5:0] FN_SLT     = 6'h2a;
	localparam logic [5:0] FN_SLTU    = 6'h2b;

	localparam logic [4:0] REG_ZERO = 5'd0;
	localparam logic [4:0] REG_V0   = 5'd2;
	localparam logic [4:0] REG_A0   = 5'd4;
	localparam logic [4:0] REG_RA   = 5'd31;

	// one data memory access, lane ordered
	typedef struct packed {
		logic                   en;
		logic [3:0]             we;
		logic [DMEM_ADDR_W-1:0] addr;
		logic [31:0]            wdata;
	} dmem_req_t;

	// one register file write
	typedef struct packed {
		logic        we;
		logic [4:0]  idx;
		logic [31:0] data;
	} rf_wr_t;

endpackage

// ===== hdl/mse_if.sv =====
// request and result channel interfaces
interface mse_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] instr;
	logic [15:0] preload_addr;
	logic [7:0]  preload_byte;

	modport source (output valid, command, instr, preload_addr, preload_byte, input ready);
	modport sink   (input valid, command, instr, preload_addr, preload_byte, output ready);
endinterface

interface mse_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] next_pc;
	logic        reg_written;
	logic [4:0]  dest_index;
	logic [31:0] dest_value;
	logic        illegal;
	logic        syscall_req;
	logic [31:0] syscall_code;
	logic [31:0] syscall_arg;

	modport source (output valid, next_pc, reg_written, dest_index, dest_value, illegal,
		syscall_req, syscall_code, syscall_arg, input ready);
	modport sink   (input valid, next_pc, reg_written, dest_index, dest_value, illegal,
		syscall_req, syscall_code, syscall_arg, output ready);
endinterface

// ===== hdl/mse_regfile.sv =====
// 32 x 32 register file, two synchronous read ports, valid bits for reset
module mse_regfile (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rd_en,
	input  logic [4:0]     ra,
	input  logic [4:0]     rb,
	output logic [31:0]    qa,
	output logic [31:0]    qb,
	input  mse_pkg::rf_wr_t wr
);
	import mse_pkg::*;

	logic [31:0] mem [32];
	logic [31:0] valid_q;
	logic [31:0] da_q, db_q;
	logic        va_q, vb_q;

	// entry valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			va_q    <= 1'b0;
			vb_q    <= 1'b0;
		end else begin
			if (wr.we) valid_q[wr.idx] <= 1'b1;
			if (rd_en) begin
				va_q <= valid_q[ra] && (ra != REG_ZERO);
				vb_q <= valid_q[rb] && (rb != REG_ZERO);
			end
		end
	end

	// storage and registered reads
	always_ff @(posedge clk) begin
		if (wr.we) mem[wr.idx] <= wr.data;
		if (rd_en) begin
			da_q <= mem[ra];
			db_q <= mem[rb];
		end
	end

	assign qa = va_q ? da_q : '0;
	assign qb = vb_q ? db_q : '0;
endmodule

// ===== hdl/mse_dmem.sv =====
// byte addressed data memory in four byte lanes, misaligned access wraps rows
module mse_dmem (
	input  logic                clk,
	input  mse_pkg::dmem_req_t  req,
	output logic [31:0]         rdata
);
	import mse_pkg::*;

	for (genvar l = 0; l < 4; l++) begin : g_lane
		logic [7:0]            mem [DMEM_ROWS];
		logic [DMEM_ROW_W-1:0] row;
		logic [7:0]            q;

		// lanes below the start lane hold bytes of the following row
		assign row = req.addr[DMEM_ADDR_W-1:2] + DMEM_ROW_W'(2'(l) < req.addr[1:0]);

		always_ff @(posedge clk) begin
			if (req.en) begin
				if (req.we[l]) mem[row] <= req.wdata[8*l +: 8];
				q <= mem[row];
			end
		end

		assign rdata[8*l +: 8] = q;
	end
endmodule

// ===== hdl/mips_subset_execute.sv =====
// mips subset execute block: decode, execute, memory access and write-back
//
//  channel | dir | fields
//  cfg     | in  | cfg_we, cfg_wdata (start_pc)
//  cmd     | in  | command, instr, preload_addr, preload_byte
//  res     | out | next_pc, reg_written, dest_index, dest_value, illegal, syscall_*
//
// three stages: register read on acceptance, execute and memory access, write-back
// into the result register; one request per cycle while the result is not stalled.
// the pc loop closes in the execute stage; register hazards are forwarded.
// reset clears pc to the start pc reset value and marks every register as zero.
// a stalled result holds the whole pipeline, memories included.
module mips_subset_execute (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	mse_in_if.sink      cmd,
	mse_out_if.source   res
);
	import mse_pkg::*;

	// start_pc acts only through reset, which restores its reset value, so the
	// written value is never observed and no register holds it

	logic adv;
	assign adv       = !res.valid || res.ready;
	assign cmd.ready = adv;

	// register read addresses, system call reads v0 and a0
	logic [4:0] ra, rb;
	logic       sys_in;
	assign sys_in = (cmd.instr[31:26] == OP_SPECIAL) && (cmd.instr[5:0] == FN_SYSCALL);
	assign ra = sys_in ? REG_V0 : cmd.instr[25:21];
	assign rb = sys_in ? REG_A0 : cmd.instr[20:16];

	logic [31:0] qa, qb;
	rf_wr_t      rf_wr;
	dmem_req_t   dreq;
	logic [31:0] dq;

	mse_regfile u_rf (
		.clk(clk), .arst_n(arst_n), .rd_en(adv), .ra(ra), .rb(rb),
		.qa(qa), .qb(qb), .wr(rf_wr)
	);

	mse_dmem u_dmem (.clk(clk), .req(dreq), .rdata(dq));

	// stage 1 registers
	logic        v_s1, cmd_s1;
	logic [31:0] instr_s1;
	logic [15:0] paddr_s1;
	logic [7:0]  pbyte_s1;
	logic [4:0]  ra_s1, rb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= cmd.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1   <= cmd.command;
			instr_s1 <= cmd.instr;
			paddr_s1 <= cmd.preload_addr;
			pbyte_s1 <= cmd.preload_byte;
			ra_s1    <= ra;
			rb_s1    <= rb;
		end
	end

	// stage 2 registers
	logic        v_s2, wr_s2, ld_s2, bad_s2, sys_s2, pre_s2;
	logic [5:0]  op_s2;
	logic [1:0]  ea0_s2;
	logic [4:0]  dst_s2;
	logic [31:0] val_s2, npc_s2, sa_s2, sb_s2;
	logic [31:0] wb_val;

	// last register write, for the read issued at the same edge
	logic        wbq_v;
	logic [4:0]  wbq_idx;
	logic [31:0] wbq_data;

	// operand forwarding
	logic [31:0] a, b;
	always_comb begin
		if (v_s2 && wr_s2 && dst_s2 == ra_s1) a = wb_val;
		else if (wbq_v && wbq_idx == ra_s1) a = wbq_data;
		else a = qa;
		if (v_s2 && wr_s2 && dst_s2 == rb_s1) b = wb_val;
		else if (wbq_v && wbq_idx == rb_s1) b = wbq_data;
		else b = qb;
	end

	logic [31:0] pc_q;

	// execute
	logic [5:0]  op, fn;
	logic [4:0]  sh, dst;
	logic [31:0] simm, zimm, ea, pc4, npc, val, jtgt, btgt;
	logic        wr, bad, sys, ld, st;
	logic [3:0]  smask;

	always_comb begin
		op   = instr_s1[31:26];
		fn   = instr_s1[5:0];
		sh   = instr_s1[10:6];
		simm = {{16{instr_s1[15]}}, instr_s1[15:0]};
		zimm = {16'd0, instr_s1[15:0]};
		ea   = a + simm;
		pc4  = pc_q + 32'd4;
		jtgt = (pc4 & JUMP_REGION) | {4'd0, instr_s1[25:0], 2'b00};
		btgt = pc4 + {simm[29:0], 2'b00};
		npc  = pc4;
		val  = '0;
		dst  = instr_s1[20:16];
		wr   = 1'b1;
		bad  = 1'b0;
		sys  = 1'b0;
		ld   = 1'b0;
		st   = 1'b0;
		smask = 4'b0000;
		if (op == OP_SPECIAL) begin
			dst = instr_s1[15:11];
			case (fn)
				FN_SLL:     val = b << sh;
				FN_SRL:     val = b >> sh;
				FN_SRA:     val = $unsigned($signed(b) >>> sh);
				FN_JR:      begin wr = 1'b0; npc = a; end
				FN_JALR:    begin val = pc4; npc = a; end
				FN_SYSCALL: begin wr = 1'b0; sys = 1'b1; end
				FN_ADDU:    val = a + b;
				FN_SUBU:    val = a - b;
				FN_AND:     val = a & b;
				FN_OR:      val = a | b;
				FN_XOR:     val = a ^ b;
				FN_NOR:     val = ~(a | b);
				FN_SLT:     val = {31'd0, $signed(a) < $signed(b)};
				FN_SLTU:    val = {31'd0, a < b};
				default:    begin bad = 1'b1; wr = 1'b0; end
			endcase
		end else begin
			case (op)
				OP_J:     begin wr = 1'b0; npc = jtgt; end
				OP_JAL:   begin dst = REG_RA; val = pc4; npc = jtgt; end
				OP_BEQ:   begin wr = 1'b0; if (a == b) npc = btgt; end
				OP_BNE:   begin wr = 1'b0; if (a != b) npc = btgt; end
				OP_ADDIU: val = ea;
				OP_SLTI:  val = {31'd0, $signed(a) < $signed(simm)};
				OP_SLTIU: val = {31'd0, a < simm};
				OP_ANDI:  val = a & zimm;
				OP_ORI:   val = a | zimm;
				OP_XORI:  val = a ^ zimm;
				OP_LUI:   val = {instr_s1[15:0], 16'd0};
				OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: ld = 1'b1;
				OP_SB:    begin wr = 1'b0; st = 1'b1; smask = 4'b0001; end
				OP_SH:    begin wr = 1'b0; st = 1'b1; smask = 4'b0011; end
				OP_SW:    begin wr = 1'b0; st = 1'b1; smask = 4'b1111; end
				default:  begin bad = 1'b1; wr = 1'b0; end
			endcase
		end
		if (bad) begin
			npc = pc_q;
			st  = 1'b0;
			ld  = 1'b0;
		end
	end

	// data memory request, store data and lane mask rotated to the start lane
	logic        exec_s1, pre_s1;
	logic [5:0]  rot_sh;
	logic [63:0] bb;
	logic [7:0]  mm;
	logic [31:0] paddr32;
	assign exec_s1 = v_s1 && (cmd_s1 == CMD_EXEC);
	assign pre_s1  = v_s1 && (cmd_s1 == CMD_PRELOAD);
	assign paddr32 = {16'd0, paddr_s1};

	always_comb begin
		rot_sh = 6'd32 - {1'b0, ea[1:0], 3'b000};
		bb     = {b, b};
		mm     = {smask, smask};
		dreq.en = adv && v_s1;
		if (pre_s1) begin
			dreq.addr  = paddr32[DMEM_ADDR_W-1:0];
			dreq.we    = 4'b0001 << paddr_s1[1:0];
			dreq.wdata = {4{pbyte_s1}};
		end else begin
			dreq.addr  = ea[DMEM_ADDR_W-1:0];
			dreq.we    = (exec_s1 && st) ? 4'(mm >> (3'd4 - {1'b0, ea[1:0]})) : 4'b0000;
			dreq.wdata = 32'(bb >> rot_sh);
		end
	end

	// pc update at the end of execute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pc_q <= START_PC_RESET;
		else if (adv && exec_s1) pc_q <= npc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pre_s2 <= pre_s1;
			wr_s2  <= exec_s1 && (wr || ld) && !bad && (dst != REG_ZERO);
			ld_s2  <= ld;
			bad_s2 <= bad;
			sys_s2 <= sys;
			op_s2  <= op;
			ea0_s2 <= ea[1:0];
			dst_s2 <= dst;
			val_s2 <= val;
			npc_s2 <= pre_s1 ? pc_q : npc;
			sa_s2  <= a;
			sb_s2  <= b;
		end
	end

	// load alignment and extension
	logic [63:0] dd;
	logic [31:0] rot;
	always_comb begin
		dd  = {dq, dq};
		rot = 32'(dd >> {ea0_s2, 3'b000});
		if (ld_s2) begin
			case (op_s2)
				OP_LB:   wb_val = {{24{rot[7]}}, rot[7:0]};
				OP_LH:   wb_val = {{16{rot[15]}}, rot[15:0]};
				OP_LBU:  wb_val = {24'd0, rot[7:0]};
				OP_LHU:  wb_val = {16'd0, rot[15:0]};
				default: wb_val = rot;
			endcase
		end else begin
			wb_val = val_s2;
		end
	end

	// register write-back
	assign rf_wr.we   = adv && v_s2 && wr_s2;
	assign rf_wr.idx  = dst_s2;
	assign rf_wr.data = wb_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wbq_v <= 1'b0;
		else if (rf_wr.we) wbq_v <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (rf_wr.we) begin
			wbq_idx  <= dst_s2;
			wbq_data <= wb_val;
		end
	end

	// result register
	logic rsys;
	assign rsys = sys_s2 && !pre_s2 && !bad_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res.valid <= 1'b0;
		else if (adv) res.valid <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res.next_pc      <= npc_s2;
			res.reg_written  <= wr_s2;
			res.dest_index   <= wr_s2 ? dst_s2 : REG_ZERO;
			res.dest_value   <= wr_s2 ? wb_val : '0;
			res.illegal      <= bad_s2 && !pre_s2;
			res.syscall_req  <= rsys;
			res.syscall_code <= rsys ? sa_s2 : '0;
			res.syscall_arg  <= rsys ? sb_s2 : '0;
		end
	end
endmodule

// ===== bench/mips_subset_execute_tb.sv =====
// self-checking testbench for the mips subset execute block
`timescale 1ns / 100ps

module mips_subset_execute_tb;
	import mse_pkg::*;

	localparam logic [5:0] OP_BAD = 6'h3f;
	localparam logic [5:0] FN_BAD = 6'h3f;

	typedef struct {
		logic        command;
		logic [31:0] instr;
		logic [15:0] preload_addr;
		logic [7:0]  preload_byte;
	} request_t;

	typedef struct {
		logic [31:0] next_pc;
		logic        reg_written;
		logic [4:0]  dest_index;
		logic [31:0] dest_value;
		logic        illegal;
		logic        syscall_req;
		logic [31:0] syscall_code;
		logic [31:0] syscall_arg;
	} result_t;

	typedef struct {
		request_t req;
		bit       typed;
		result_t  res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	mse_in_if  cmd_ch ();
	mse_out_if res_ch ();

	mips_subset_execute uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch.sink),
		.res       (res_ch.source)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// architectural state of the core as seen by the bench
	logic [31:0] arch_pc;
	logic [31:0] arch_start_pc;
	logic [31:0] arch_regs [32];
	logic [7:0]  arch_mem [DMEM_BYTES];
	bit          mem_known [DMEM_BYTES];
	int          known_addrs [$];
	result_t     pending_results [$];
	dir_row_t    dir_rows [$];
	int          errors = 0;
	int          burst_left = 0;

	function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
		logic [4:0] rd, logic [4:0] sh);
		return {OP_SPECIAL, rs, rt, rd, sh, fn};
	endfunction

	function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
		logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] sx16(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] mem_get(logic [31:0] addr, int nbytes);
		logic [31:0] v;
		v = 0;
		for (int i = 0; i < nbytes; i++)
			v[8*i +: 8] = arch_mem[16'(addr + i)];
		return v;
	endfunction

	function automatic void mem_put(logic [31:0] addr, int nbytes, logic [31:0] v);
		logic [15:0] a;
		for (int i = 0; i < nbytes; i++) begin
			a = 16'(addr + i);
			arch_mem[a] = v[8*i +: 8];
			if (!mem_known[a]) begin
				mem_known[a] = 1;
				known_addrs.push_back(a);
			end
		end
	endfunction

	// execute one request against the architectural state
	function automatic void execute_item(request_t r, output result_t o);
		logic [31:0] ins, pc4, a, b, ea, npc, val, imm_x, m;
		logic [5:0]  op, fn;
		logic [4:0]  rs, rt, rd, sh, dst;
		bit          wr, bad, sys;
		ins = r.instr;
		op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16];
		rd = ins[15:11]; sh = ins[10:6];  fn = ins[5:0];
		imm_x = sx16(ins[15:0]);
		pc4 = arch_pc + 4;
		a = arch_regs[rs];
		b = arch_regs[rt];
		ea = a + imm_x;
		npc = pc4; val = 0; dst = 0; m = 0;
		wr = 1; bad = 0; sys = 0;
		o = '{default: '0};
		if (r.command == CMD_PRELOAD) begin
			mem_put({16'h0, r.preload_addr}, 1, {24'h0, r.preload_byte});
			o.next_pc = arch_pc;
			return;
		end
		if (op == OP_SPECIAL) begin
			dst = rd;
			case (fn)
				FN_SLL:     val = b << sh;
				FN_SRL:     val = b >> sh;
				FN_SRA:     val = $signed(b) >>> sh;
				FN_JR: begin wr = 0; npc = a; end
				FN_JALR: begin val = pc4; npc = a; end
				FN_SYSCALL: begin wr = 0; sys = 1; end
				FN_ADDU:    val = a + b;
				FN_SUBU:    val = a - b;
				FN_AND:     val = a & b;
				FN_OR:      val = a | b;
				FN_XOR:     val = a ^ b;
				FN_NOR:     val = ~(a | b);
				FN_SLT:     val = ($signed(a) < $signed(b)) ? 1 : 0;
				FN_SLTU:    val = (a < b) ? 1 : 0;
				default: begin bad = 1; wr = 0; end
			endcase
		end else begin
			dst = rt;
			case (op)
				OP_J: begin wr = 0; npc = (pc4 & JUMP_REGION) | {ins[25:0], 2'b00}; end
				OP_JAL: begin
					dst = REG_RA; val = pc4;
					npc = (pc4 & JUMP_REGION) | {ins[25:0], 2'b00};
				end
				OP_BEQ: begin wr = 0; if (a == b) npc = pc4 + (imm_x << 2); end
				OP_BNE: begin wr = 0; if (a != b) npc = pc4 + (imm_x << 2); end
				OP_ADDIU: val = ea;
				OP_SLTI:  val = ($signed(a) < $signed(imm_x)) ? 1 : 0;
				OP_SLTIU: val = (a < imm_x) ? 1 : 0;
				OP_ANDI:  val = a & {16'h0, ins[15:0]};
				OP_ORI:   val = a | {16'h0, ins[15:0]};
				OP_XORI:  val = a ^ {16'h0, ins[15:0]};
				OP_LUI:   val = {ins[15:0], 16'h0};
				OP_LB: begin m = mem_get(ea, 1); val = {{24{m[7]}}, m[7:0]}; end
				OP_LH: begin m = mem_get(ea, 2); val = sx16(m[15:0]); end
				OP_LW:    val = mem_get(ea, 4);
				OP_LBU:   val = mem_get(ea, 1);
				OP_LHU:   val = mem_get(ea, 2);
				OP_SB: begin wr = 0; mem_put(ea, 1, b); end
				OP_SH: begin wr = 0; mem_put(ea, 2, b); end
				OP_SW: begin wr = 0; mem_put(ea, 4, b); end
				default: begin bad = 1; wr = 0; end
			endcase
		end
		if (bad) begin
			o.next_pc = arch_pc;
			o.illegal = 1;
			return;
		end
		if (wr && dst != REG_ZERO) begin
			arch_regs[dst] = val;
			o.reg_written = 1;
			o.dest_index = dst;
			o.dest_value = val;
		end
		arch_pc = npc;
		o.next_pc = npc;
		if (sys) begin
			o.syscall_req = 1;
			o.syscall_code = arch_regs[REG_V0];
			o.syscall_arg = arch_regs[REG_A0];
		end
	endfunction

	// drive one request, called at a rising edge, returns at its acceptance edge
	task automatic send_req(request_t r, bit typed, result_t want);
		result_t got;
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.command      <= r.command;
		cmd_ch.instr        <= r.instr;
		cmd_ch.preload_addr <= r.preload_addr;
		cmd_ch.preload_byte <= r.preload_byte;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		execute_item(r, got);
		pending_results.push_back(typed ? want : got);
		burst_left--;
	endtask

	// drop valid and hold off until every result is back
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_start_pc(logic [31:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		arch_start_pc = v;
		@(posedge clk);
	endtask

	function automatic bit legal_op(logic [5:0] op);
		case (op)
			OP_SPECIAL, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDIU, OP_SLTI, OP_SLTIU,
			OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
			OP_SB, OP_SH, OP_SW: return 1;
			default: return 0;
		endcase
	endfunction

	function automatic bit legal_fn(logic [5:0] fn);
		case (fn)
			FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_JALR, FN_SYSCALL, FN_ADDU, FN_SUBU,
			FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU: return 1;
			default: return 0;
		endcase
	endfunction

	// random request shaped from the current state
	function automatic request_t random_req();
		request_t    r;
		int          pick, n, t;
		logic [5:0]  op, fn;
		logic [4:0]  rs, rt, rd;
		logic [5:0]  alu_fns [12];
		logic [5:0]  imm_ops [8];
		logic [5:0]  ld_ops [5];
		logic [5:0]  st_ops [3];
		logic [5:0]  br_ops [4];
		bit          ok;
		alu_fns = '{FN_SLL, FN_SRL, FN_SRA, FN_ADDU, FN_SUBU, FN_AND, FN_OR, FN_XOR,
			FN_NOR, FN_SLT, FN_SLTU, FN_JALR};
		imm_ops = '{OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LUI};
		ld_ops = '{OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU};
		st_ops = '{OP_SB, OP_SH, OP_SW};
		br_ops = '{OP_BEQ, OP_BNE, OP_J, OP_JAL};
		r.command = CMD_EXEC;
		r.instr = $urandom;
		r.preload_addr = 16'($urandom);
		r.preload_byte = 8'($urandom);
		rs = 5'($urandom); rt = 5'($urandom); rd = 5'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			r.command = CMD_PRELOAD;
			if ($urandom_range(0, 3) == 0)
				r.preload_addr = 16'(16'hfff8 + $urandom_range(0, 15));
		end else if (pick < 16) begin
			if ($urandom_range(0, 1)) begin
				do op = 6'($urandom); while (legal_op(op));
				r.instr[31:26] = op;
			end else begin
				do fn = 6'($urandom); while (legal_fn(fn));
				r.instr = enc_r(fn, rs, rt, rd, 5'($urandom));
				r.instr[10:6] = 5'($urandom);
			end
		end else if (pick < 38) begin
			r.instr = enc_r(alu_fns[$urandom_range(0, 10)], rs, rt, rd, 5'($urandom));
			if ($urandom_range(0, 40) == 0)
				r.instr[5:0] = FN_JALR;
		end else if (pick < 60) begin
			r.instr = enc_i(imm_ops[$urandom_range(0, 7)], rs, rt, 16'($urandom));
		end else if (pick < 76 && known_addrs.size() != 0) begin
			op = ld_ops[$urandom_range(0, 4)];
			n = (op == OP_LW) ? 4 : (op == OP_LH || op == OP_LHU) ? 2 : 1;
			t = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
			ok = 1;
			for (int i = 0; i < n; i++)
				if (!mem_known[16'(t + i)]) ok = 0;
			if (!ok) op = ($urandom_range(0, 1)) ? OP_LB : OP_LBU;
			r.instr = enc_i(op, rs, rt, 16'(t - arch_regs[rs]));
		end else if (pick < 88) begin
			r.instr = enc_i(st_ops[$urandom_range(0, 2)], rs, rt, 16'($urandom));
		end else if (pick < 97) begin
			r.instr = enc_i(br_ops[$urandom_range(0, 3)], rs, rt, 16'($urandom));
			if ($urandom_range(0, 2) == 0) r.instr[20:16] = rs;
			if ($urandom_range(0, 5) == 0) r.instr = enc_r(FN_JR, rs, rt, rd, 5'($urandom));
		end else begin
			r.instr = enc_r(FN_SYSCALL, rs, rt, rd, 5'($urandom));
			r.instr[25:6] = 20'($urandom);
		end
		return r;
	endfunction

	task automatic run_random(int n);
		for (int i = 0; i < n; i++)
			send_req(random_req(), 0, '{default: '0});
	endtask

	function automatic void add_row(request_t r, bit typed, result_t w);
		dir_row_t d;
		d.req = r; d.typed = typed; d.res = w;
		dir_rows.push_back(d);
	endfunction

	function automatic request_t ex(logic [31:0] ins);
		return '{CMD_EXEC, ins, 16'h0, 8'h0};
	endfunction

	function automatic request_t pre(logic [15:0] a, logic [7:0] v);
		return '{CMD_PRELOAD, 32'h0, a, v};
	endfunction

	function automatic result_t rv(logic [31:0] pc, logic w, logic [4:0] i, logic [31:0] v,
		logic bad);
		return '{pc, w, i, v, bad, 1'b0, 32'h0, 32'h0};
	endfunction

	// directed table: extremes, every operation class and the special cases
	function automatic void build_directed();
		result_t none;
		none = '{default: '0};
		// illegal opcode and function code leave the pc at its reset value
		add_row(ex(enc_i(OP_BAD, 5'd1, 5'd2, 16'hffff)), 1, rv(START_PC_RESET, 0, 0, 0, 1));
		add_row(ex(enc_r(FN_BAD, 5'd1, 5'd2, 5'd3, 5'd0)), 1, rv(START_PC_RESET, 0, 0, 0, 1));
		// preloads around the address wrap
		add_row(pre(16'hffff, 8'h80), 1, rv(START_PC_RESET, 0, 0, 0, 0));
		add_row(pre(16'h0000, 8'h7f), 1, rv(START_PC_RESET, 0, 0, 0, 0));
		add_row(pre(16'h0001, 8'hff), 1, rv(START_PC_RESET, 0, 0, 0, 0));
		add_row(pre(16'h0002, 8'h01), 1, rv(START_PC_RESET, 0, 0, 0, 0));
		add_row(ex(enc_i(OP_LUI, 5'd0, 5'd1, 16'hffff)), 1, rv(32'h1004, 1, 1, 32'hffff0000, 0));
		add_row(ex(enc_i(OP_ORI, 5'd1, 5'd1, 16'hffff)), 1, rv(32'h1008, 1, 1, 32'hffffffff, 0));
		// write to register zero is dropped
		add_row(ex(enc_i(OP_ADDIU, 5'd1, 5'd0, 16'h0005)), 1, rv(32'h100c, 0, 0, 0, 0));
		add_row(ex(enc_i(OP_LB, 5'd0, 5'd2, 16'hffff)), 1, rv(32'h1010, 1, 2, 32'hffffff80, 0));
		// misaligned word across the wrap
		add_row(ex(enc_i(OP_LW, 5'd0, 5'd3, 16'hffff)), 0, none);
		add_row(ex(enc_i(OP_SLTI, 5'd1, 5'd5, 16'hffff)), 0, none);
		add_row(ex(enc_i(OP_SLTIU, 5'd0, 5'd6, 16'h8000)), 0, none);
		add_row(ex(enc_r(FN_SRA, 5'd0, 5'd2, 5'd7, 5'd31)), 0, none);
		add_row(ex(enc_r(FN_SUBU, 5'd0, 5'd1, 5'd8, 5'd0)), 0, none);
		add_row(ex(enc_r(FN_SLT, 5'd1, 5'd8, 5'd9, 5'd0)), 0, none);
		add_row(ex(enc_r(FN_SLTU, 5'd1, 5'd8, 5'd10, 5'd0)), 0, none);
		add_row(ex(enc_r(FN_ADDU, 5'd1, 5'd1, 5'd4, 5'd0)), 0, none);
		add_row(ex(enc_i(OP_SH, 5'd0, 5'd1, 16'hfffe)), 0, none);
		add_row(ex(enc_i(OP_LHU, 5'd0, 5'd11, 16'hffff)), 0, none);
		add_row(ex(enc_i(OP_SB, 5'd0, 5'd2, 16'h0003)), 0, none);
		add_row(ex(enc_i(OP_LH, 5'd0, 5'd12, 16'h0002)), 0, none);
		add_row(ex(enc_i(OP_ADDIU, 5'd0, 5'd2, 16'h000a)), 0, none);
		add_row(ex(enc_r(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0)), 0, none);
		add_row(ex(enc_i(OP_BEQ, 5'd0, 5'd0, 16'hffff)), 0, none);
		add_row(ex(enc_i(OP_BNE, 5'd0, 5'd0, 16'h0005)), 0, none);
		add_row(ex({OP_JAL, 26'h3ffffff}), 0, none);
		add_row(ex(enc_r(FN_JALR, 5'd1, 5'd0, 5'd13, 5'd0)), 0, none);
	endfunction

	// result checker and ready pattern
	int stall_mode = 0;
	always @(posedge clk) begin
		result_t w;
		if (res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected, next_pc %h", res_ch.next_pc);
				errors++;
			end else begin
				w = pending_results.pop_front();
				if (res_ch.next_pc !== w.next_pc) begin
					$error("next_pc exp %h got %h", w.next_pc, res_ch.next_pc); errors++;
				end
				if (res_ch.reg_written !== w.reg_written) begin
					$error("reg_written exp %h got %h", w.reg_written, res_ch.reg_written);
					errors++;
				end
				if (res_ch.dest_index !== w.dest_index) begin
					$error("dest_index exp %h got %h", w.dest_index, res_ch.dest_index);
					errors++;
				end
				if (res_ch.dest_value !== w.dest_value) begin
					$error("dest_value exp %h got %h", w.dest_value, res_ch.dest_value);
					errors++;
				end
				if (res_ch.illegal !== w.illegal) begin
					$error("illegal exp %h got %h", w.illegal, res_ch.illegal); errors++;
				end
				if (res_ch.syscall_req !== w.syscall_req) begin
					$error("syscall_req exp %h got %h", w.syscall_req, res_ch.syscall_req);
					errors++;
				end
				if (res_ch.syscall_code !== w.syscall_code) begin
					$error("syscall_code exp %h got %h", w.syscall_code, res_ch.syscall_code);
					errors++;
				end
				if (res_ch.syscall_arg !== w.syscall_arg) begin
					$error("syscall_arg exp %h got %h", w.syscall_arg, res_ch.syscall_arg);
					errors++;
				end
			end
		end
		if ($urandom_range(0, 31) == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: res_ch.ready <= 1'b1;
			1: res_ch.ready <= 1'($urandom_range(0, 1));
			2: res_ch.ready <= ($urandom_range(0, 3) == 0);
			default: res_ch.ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// main sequence
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 32'h0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_EXEC;
		cmd_ch.instr = 32'h0;
		cmd_ch.preload_addr = 16'h0;
		cmd_ch.preload_byte = 8'h0;
		arch_pc = START_PC_RESET;
		arch_start_pc = START_PC_RESET;
		foreach (arch_regs[i]) arch_regs[i] = 32'h0;
		build_directed();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// start pc only matters at reset, so writes must leave the running pc alone
		write_start_pc(32'hffffffff);
		foreach (dir_rows[i])
			send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
		drain();
		write_start_pc(32'h0);
		run_random(250);
		drain();
		write_start_pc($urandom);
		run_random(250);
		drain();
		write_start_pc(START_PC_RESET);
		run_random(250);
		drain();
		if (errors == 0)
			$display("mips_subset_execute verification clean");
		else
			$display("mips_subset_execute verification failed");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("mips_subset_execute verification failed");
		$finish;
	end

endmodule
